// ----- src/ctlt_pkg.sv -----
// Shared types and constants of the C-like token lexer.
package ctlt_pkg;

   localparam int unsigned KIND_BITS = 5;
   localparam int unsigned FIELD_BITS = 16;
   localparam int unsigned RSP_DATA_BITS = 32;
   localparam int unsigned BYTE_BITS = 8;

   localparam logic [KIND_BITS-1:0] KIND_COLON = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_SEMICOLON = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_COMMA = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_ASTERISK = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_HASH = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_PERIOD = 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN = 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_LBRACKET = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_RBRACKET = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_END = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_CHAR = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_STRING = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_IDENT = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 5'd16;

   localparam logic [BYTE_BITS-1:0] CH_NUL = 8'h00;
   localparam logic [BYTE_BITS-1:0] CH_TAB = 8'h09;
   localparam logic [BYTE_BITS-1:0] CH_LF = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CH_VT = 8'h0B;
   localparam logic [BYTE_BITS-1:0] CH_CR = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_BITS-1:0] CH_DQUOTE = 8'h22;
   localparam logic [BYTE_BITS-1:0] CH_HASH = 8'h23;
   localparam logic [BYTE_BITS-1:0] CH_SQUOTE = 8'h27;
   localparam logic [BYTE_BITS-1:0] CH_LPAREN = 8'h28;
   localparam logic [BYTE_BITS-1:0] CH_RPAREN = 8'h29;
   localparam logic [BYTE_BITS-1:0] CH_STAR = 8'h2A;
   localparam logic [BYTE_BITS-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_BITS-1:0] CH_PERIOD = 8'h2E;
   localparam logic [BYTE_BITS-1:0] CH_SLASH = 8'h2F;
   localparam logic [BYTE_BITS-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_BITS-1:0] CH_SEMICOLON = 8'h3B;
   localparam logic [BYTE_BITS-1:0] CH_LBRACKET = 8'h5B;
   localparam logic [BYTE_BITS-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [BYTE_BITS-1:0] CH_RBRACKET = 8'h5D;
   localparam logic [BYTE_BITS-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [BYTE_BITS-1:0] CH_LBRACE = 8'h7B;
   localparam logic [BYTE_BITS-1:0] CH_RBRACE = 8'h7D;

   typedef struct packed {
      logic [KIND_BITS-1:0] token_kind;
      logic [FIELD_BITS-1:0] token_start;
      logic [FIELD_BITS-1:0] token_length;
      logic last_of_run;
   } token_type;

   function automatic logic is_alpha(input logic [BYTE_BITS-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [BYTE_BITS-1:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_eol(input logic [BYTE_BITS-1:0] c);
      return c == CH_LF || c == CH_CR || c == CH_VT;
   endfunction

endpackage

// ----- src/ctlt_lex.sv -----
// Lexer state registers and the per-byte mode transition with token generation.
module ctlt_lex #(
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic [ctlt_pkg::BYTE_BITS-1:0] text_byte,
   output logic [1:0] token_count,
   output ctlt_pkg::token_type token0,
   output ctlt_pkg::token_type token1
);

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_SLASH,
      MODE_LINE,
      MODE_BLOCK,
      MODE_BLOCK_STAR,
      MODE_IDENT,
      MODE_STRING,
      MODE_STRING_ESC,
      MODE_CHAR,
      MODE_CHAR_ESC
   } mode_type;

   mode_type mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] ostart_ff, ostart_in;
   logic [POSITION_BITS-1:0] olen_ff, olen_in;

   logic use_idle;
   logic idle_emit;
   logic [ctlt_pkg::KIND_BITS-1:0] idle_kind;
   logic idle_end;
   logic close_emit;
   logic [ctlt_pkg::KIND_BITS-1:0] close_kind;
   logic [POSITION_BITS-1:0] close_start;
   logic [POSITION_BITS-1:0] close_len;
   logic saw_end;
   logic is_quote;
   logic [POSITION_BITS-1:0] pos_inc;

   function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
      return (v == POS_MAX) ? v : v + 1'b1;
   endfunction

   assign pos_inc = sat_inc(pos_ff);

   always_comb begin
      mode_in = mode_ff;
      ostart_in = ostart_ff;
      olen_in = olen_ff;
      use_idle = 1'b0;
      idle_emit = 1'b0;
      idle_kind = ctlt_pkg::KIND_UNKNOWN;
      idle_end = 1'b0;
      close_emit = 1'b0;
      close_kind = ctlt_pkg::KIND_UNKNOWN;
      close_start = ostart_ff;
      close_len = olen_ff;
      is_quote = 1'b0;

      unique case (mode_ff)
         MODE_SLASH: begin
            if (text_byte == ctlt_pkg::CH_SLASH) begin
               mode_in = MODE_LINE;
            end else if (text_byte == ctlt_pkg::CH_STAR) begin
               mode_in = MODE_BLOCK;
            end else begin
               close_emit = 1'b1;
               close_kind = ctlt_pkg::KIND_UNKNOWN;
               close_len = POSITION_BITS'(1);
               use_idle = 1'b1;
            end
         end
         MODE_LINE: begin
            if (text_byte == ctlt_pkg::CH_NUL) begin
               use_idle = 1'b1;
            end else if (ctlt_pkg::is_eol(text_byte)) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_BLOCK: begin
            if (text_byte == ctlt_pkg::CH_NUL) begin
               use_idle = 1'b1;
            end else if (text_byte == ctlt_pkg::CH_STAR) begin
               mode_in = MODE_BLOCK_STAR;
            end
         end
         MODE_BLOCK_STAR: begin
            if (text_byte == ctlt_pkg::CH_NUL) begin
               use_idle = 1'b1;
            end else if (text_byte == ctlt_pkg::CH_SLASH) begin
               mode_in = MODE_IDLE;
            end else if (text_byte != ctlt_pkg::CH_STAR) begin
               mode_in = MODE_BLOCK;
            end
         end
         MODE_IDENT: begin
            if (ctlt_pkg::is_alpha(text_byte) || ctlt_pkg::is_digit(text_byte) ||
                text_byte == ctlt_pkg::CH_UNDERSCORE) begin
               olen_in = sat_inc(olen_ff);
            end else begin
               close_emit = 1'b1;
               close_kind = ctlt_pkg::KIND_IDENT;
               use_idle = 1'b1;
            end
         end
         MODE_STRING, MODE_STRING_ESC, MODE_CHAR, MODE_CHAR_ESC: begin
            is_quote = (mode_ff == MODE_STRING || mode_ff == MODE_STRING_ESC) ?
                       (text_byte == ctlt_pkg::CH_DQUOTE) :
                       (text_byte == ctlt_pkg::CH_SQUOTE);
            if (text_byte == ctlt_pkg::CH_NUL) begin
               use_idle = 1'b1;
            end else if (mode_ff == MODE_STRING_ESC) begin
               olen_in = sat_inc(olen_ff);
               mode_in = MODE_STRING;
            end else if (mode_ff == MODE_CHAR_ESC) begin
               olen_in = sat_inc(olen_ff);
               mode_in = MODE_CHAR;
            end else if (is_quote) begin
               close_emit = 1'b1;
               close_kind = (mode_ff == MODE_STRING) ? ctlt_pkg::KIND_STRING :
                                                       ctlt_pkg::KIND_CHAR;
               mode_in = MODE_IDLE;
            end else begin
               olen_in = sat_inc(olen_ff);
               if (text_byte == ctlt_pkg::CH_BACKSLASH) begin
                  mode_in = (mode_ff == MODE_STRING) ? MODE_STRING_ESC : MODE_CHAR_ESC;
               end
            end
         end
         default: begin
            use_idle = 1'b1;
         end
      endcase

      if (use_idle) begin
         mode_in = MODE_IDLE;
         unique case (text_byte)
            ctlt_pkg::CH_NUL: begin
               idle_emit = 1'b1;
               idle_kind = ctlt_pkg::KIND_END;
               idle_end = 1'b1;
            end
            ctlt_pkg::CH_SPACE, ctlt_pkg::CH_TAB, ctlt_pkg::CH_LF,
            ctlt_pkg::CH_CR, ctlt_pkg::CH_VT: begin
               idle_emit = 1'b0;
            end
            ctlt_pkg::CH_SLASH: begin
               mode_in = MODE_SLASH;
               ostart_in = pos_ff;
               olen_in = POSITION_BITS'(1);
            end
            ctlt_pkg::CH_COLON: begin
               idle_emit = 1'b1;
               idle_kind = ctlt_pkg::KIND_COLON;
            end
            ctlt_pkg::CH_SEMICOLON: begin
               idle_emit = 1'b1;
               idle_kind = ctlt_pkg::KIND_SEMICOLON;
            end
            ctlt_pkg::CH_COMMA: begin
               idle_emit = 1'b1;
               idle_kind = ctlt_pkg::KIND_COMMA;
            end
            ctlt_pkg::CH_STAR: begin
               idle_emit = 1'b1;
               idle_kind = ctlt_pkg::KIND_ASTERISK;
            end
            ctlt_pkg::CH_HASH: begin
               idle_emit = 1'b1;
               idle_kind = ctlt_pkg::KIND_HASH;
            end
            ctlt_pkg::CH_PERIOD: begin
               idle_emit = 1'b1;
               idle_kind = ctlt_pkg::KIND_PERIOD;
            end
            ctlt_pkg::CH_LPAREN: begin
               idle_emit = 1'b1;
               idle_kind = ctlt_pkg::KIND_LPAREN;
            end
            ctlt_pkg::CH_RPAREN: begin
               idle_emit = 1'b1;
               idle_kind = ctlt_pkg::KIND_RPAREN;
            end
            ctlt_pkg::CH_LBRACE: begin
               idle_emit = 1'b1;
               idle_kind = ctlt_pkg::KIND_LBRACE;
            end
            ctlt_pkg::CH_RBRACE: begin
               idle_emit = 1'b1;
               idle_kind = ctlt_pkg::KIND_RBRACE;
            end
            ctlt_pkg::CH_LBRACKET: begin
               idle_emit = 1'b1;
               idle_kind = ctlt_pkg::KIND_LBRACKET;
            end
            ctlt_pkg::CH_RBRACKET: begin
               idle_emit = 1'b1;
               idle_kind = ctlt_pkg::KIND_RBRACKET;
            end
            ctlt_pkg::CH_SQUOTE: begin
               mode_in = MODE_CHAR;
               ostart_in = pos_inc;
               olen_in = '0;
            end
            ctlt_pkg::CH_DQUOTE: begin
               mode_in = MODE_STRING;
               ostart_in = pos_inc;
               olen_in = '0;
            end
            default: begin
               if (ctlt_pkg::is_alpha(text_byte) ||
                   text_byte == ctlt_pkg::CH_UNDERSCORE) begin
                  mode_in = MODE_IDENT;
                  ostart_in = pos_ff;
                  olen_in = POSITION_BITS'(1);
               end else begin
                  idle_emit = 1'b1;
                  idle_kind = ctlt_pkg::is_digit(text_byte) ? ctlt_pkg::KIND_IDENT :
                                                              ctlt_pkg::KIND_UNKNOWN;
               end
            end
         endcase
      end

      saw_end = idle_end;
      pos_in = pos_inc;
      if (saw_end) begin
         mode_in = MODE_IDLE;
         pos_in = '0;
         ostart_in = '0;
         olen_in = '0;
      end
   end

   always_comb begin
      token_count = 2'({1'b0, close_emit} + {1'b0, idle_emit});
      token0.token_kind = close_emit ? close_kind : idle_kind;
      token0.token_start = close_emit ? 16'(close_start) : 16'(pos_ff);
      token0.token_length = close_emit ? 16'(close_len) : 16'd1;
      token0.last_of_run = !(close_emit && idle_emit);
      token1.token_kind = idle_kind;
      token1.token_start = 16'(pos_ff);
      token1.token_length = 16'd1;
      token1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff <= '0;
         ostart_ff <= '0;
         olen_ff <= '0;
      end else if (advance) begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         ostart_ff <= ostart_in;
         olen_ff <= olen_in;
      end
   end

endmodule

// ----- src/ctlt_rsp_queue.sv -----
// Three-entry result buffer that takes up to two tokens per cycle and hands out one.
module ctlt_rsp_queue (
   input  logic clock,
   input  logic reset,
   input  logic [1:0] push_count,
   input  ctlt_pkg::token_type push0,
   input  ctlt_pkg::token_type push1,
   input  logic pop_ready,
   output logic head_valid,
   output ctlt_pkg::token_type head,
   output logic [1:0] room
);

   ctlt_pkg::token_type entry_ff [3];
   ctlt_pkg::token_type entry_in [3];
   logic [1:0] count_ff, count_in;
   logic pop;
   logic [1:0] base;

   assign head_valid = count_ff != 2'd0;
   assign head = entry_ff[0];
   assign room = 2'd3 - count_ff;
   assign pop = head_valid && pop_ready;
   assign base = count_ff - {1'b0, pop};

   always_comb begin
      entry_in[0] = pop ? entry_ff[1] : entry_ff[0];
      entry_in[1] = pop ? entry_ff[2] : entry_ff[1];
      entry_in[2] = entry_ff[2];
      for (int i = 0; i < 3; i++) begin
         if (push_count != 2'd0 && base == 2'(i)) begin
            entry_in[i] = push0;
         end
         if (push_count == 2'd2 && 2'(base + 2'd1) == 2'(i)) begin
            entry_in[i] = push1;
         end
      end
      count_in = 2'(base + push_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

endmodule

// ----- src/c_like_token_lexer_core.sv -----
// Top level of the C-like token lexer: input register, lexer and result buffer.
//
// The req_ channel carries one text byte per word; a zero byte marks the end of
// the text. The rsp_ channel carries tokens: the kind on tuser, start offset and
// length of the token text on tdata, with tlast high on the final token caused
// by one input byte. Whitespace and comments give no token, most bytes give one,
// and a byte that closes an identifier or a pending slash and forms a token of
// its own gives two. A byte is registered on acceptance and lexed from that
// register; its tokens are written into a three-entry result buffer once the
// buffer has room for all of them, and the head of the buffer is valid on rsp_.
// One byte is taken per cycle while the receiver keeps up; a byte that gives
// two tokens holds the input until the buffer can take both. When the receiver
// stalls the buffer fills and req_tready falls; no token is lost. Reset clears
// the lexer to its idle mode at offset zero and empties the buffer. Offsets
// and lengths saturate at 2^POSITION_BITS - 1 and are reported in their low
// 16 bits.
module c_like_token_lexer_core #(
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [ctlt_pkg::RSP_DATA_BITS-1:0] rsp_tdata, // [15:0] token_start,
                                                         // [31:16] token_length
   output logic [ctlt_pkg::KIND_BITS-1:0] rsp_tuser,     // [4:0] token_kind
   output logic rsp_tlast          // last_of_run
);

   logic [ctlt_pkg::BYTE_BITS-1:0] byte_ff, byte_in;
   logic byte_valid_ff, byte_valid_in;
   logic accept;
   logic advance;
   logic [1:0] token_count;
   logic [1:0] room;
   ctlt_pkg::token_type token0;
   ctlt_pkg::token_type token1;
   ctlt_pkg::token_type head;

   assign advance = byte_valid_ff && (token_count <= room);
   assign req_tready = !byte_valid_ff || advance;
   assign accept = req_tvalid && req_tready;
   assign byte_in = accept ? req_tdata : byte_ff;
   assign byte_valid_in = accept || (byte_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   ctlt_lex #(
      .POSITION_BITS(POSITION_BITS)
   ) u_lex (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .text_byte(byte_ff),
      .token_count(token_count),
      .token0(token0),
      .token1(token1)
   );

   ctlt_rsp_queue u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push_count(advance ? token_count : 2'd0),
      .push0(token0),
      .push1(token1),
      .pop_ready(rsp_tready),
      .head_valid(rsp_tvalid),
      .head(head),
      .room(room)
   );

   assign rsp_tdata = {head.token_length, head.token_start};
   assign rsp_tuser = head.token_kind;
   assign rsp_tlast = head.last_of_run;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench of the C-like token lexer with its own token predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned PHASE_BYTES = 370;
   localparam int unsigned MAX_PRINTS = 50;

   localparam logic [ctlt_pkg::BYTE_BITS-1:0] CH_LOWER_A = 8'h61;
   localparam logic [ctlt_pkg::BYTE_BITS-1:0] CH_UPPER_A = 8'h41;
   localparam logic [ctlt_pkg::BYTE_BITS-1:0] CH_DIGIT_0 = 8'h30;
   localparam logic [ctlt_pkg::FIELD_BITS-1:0] ONE_LEN = 16'd1;

   typedef enum logic [3:0] {
      LX_IDLE, LX_SLASH, LX_LINE, LX_BLOCK, LX_BLOCK_STAR,
      LX_IDENT, LX_STRING, LX_STRING_ESC, LX_CHAR, LX_CHAR_ESC
   } lex_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;     // [7:0] text_byte
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [15:0] start, [31:16] length
   logic [4:0] rsp_tuser;          // [4:0] kind
   logic rsp_tlast;                // last_of_run

   c_like_token_lexer_core DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   logic [ctlt_pkg::BYTE_BITS-1:0] text_bytes[$];
   ctlt_pkg::token_type expected_tokens[$];
   ctlt_pkg::token_type run_tokens[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned mismatches = 0;
   int unsigned tokens_seen = 0;
   int unsigned cycle_count = 0;

   lex_mode_type lx_mode = LX_IDLE;
   logic [ctlt_pkg::FIELD_BITS-1:0] text_offset = '0;
   logic [ctlt_pkg::FIELD_BITS-1:0] open_start = '0;
   logic [ctlt_pkg::FIELD_BITS-1:0] open_len = '0;

   function automatic logic [ctlt_pkg::FIELD_BITS-1:0] bump(
      input logic [ctlt_pkg::FIELD_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic is_letter(input logic [ctlt_pkg::BYTE_BITS-1:0] b);
      return (b >= CH_LOWER_A && b < CH_LOWER_A + 8'd26) ||
             (b >= CH_UPPER_A && b < CH_UPPER_A + 8'd26);
   endfunction

   function automatic logic is_numeral(input logic [ctlt_pkg::BYTE_BITS-1:0] b);
      return b >= CH_DIGIT_0 && b < CH_DIGIT_0 + 8'd10;
   endfunction

   function automatic void add_token(input logic [ctlt_pkg::KIND_BITS-1:0] kind,
                                     input logic [ctlt_pkg::FIELD_BITS-1:0] start,
                                     input logic [ctlt_pkg::FIELD_BITS-1:0] len);
      ctlt_pkg::token_type tok;
      tok.token_kind = kind;
      tok.token_start = start;
      tok.token_length = len;
      tok.last_of_run = 1'b0;
      run_tokens.push_back(tok);
   endfunction

   // Lexes a byte that arrives between tokens; returns 1 on end of text.
   function automatic bit scan_fresh(input logic [ctlt_pkg::BYTE_BITS-1:0] b);
      bit ended = 1'b0;
      lx_mode = LX_IDLE;
      case (b)
         ctlt_pkg::CH_NUL: begin
            add_token(ctlt_pkg::KIND_END, text_offset, ONE_LEN);
            ended = 1'b1;
         end
         ctlt_pkg::CH_SPACE, ctlt_pkg::CH_TAB, ctlt_pkg::CH_LF, ctlt_pkg::CH_CR,
         ctlt_pkg::CH_VT: ;
         ctlt_pkg::CH_SLASH: begin
            lx_mode = LX_SLASH;
            open_start = text_offset;
            open_len = ONE_LEN;
         end
         ctlt_pkg::CH_COLON: add_token(ctlt_pkg::KIND_COLON, text_offset, ONE_LEN);
         ctlt_pkg::CH_SEMICOLON: add_token(ctlt_pkg::KIND_SEMICOLON, text_offset, ONE_LEN);
         ctlt_pkg::CH_COMMA: add_token(ctlt_pkg::KIND_COMMA, text_offset, ONE_LEN);
         ctlt_pkg::CH_STAR: add_token(ctlt_pkg::KIND_ASTERISK, text_offset, ONE_LEN);
         ctlt_pkg::CH_HASH: add_token(ctlt_pkg::KIND_HASH, text_offset, ONE_LEN);
         ctlt_pkg::CH_PERIOD: add_token(ctlt_pkg::KIND_PERIOD, text_offset, ONE_LEN);
         ctlt_pkg::CH_LPAREN: add_token(ctlt_pkg::KIND_LPAREN, text_offset, ONE_LEN);
         ctlt_pkg::CH_RPAREN: add_token(ctlt_pkg::KIND_RPAREN, text_offset, ONE_LEN);
         ctlt_pkg::CH_LBRACE: add_token(ctlt_pkg::KIND_LBRACE, text_offset, ONE_LEN);
         ctlt_pkg::CH_RBRACE: add_token(ctlt_pkg::KIND_RBRACE, text_offset, ONE_LEN);
         ctlt_pkg::CH_LBRACKET: add_token(ctlt_pkg::KIND_LBRACKET, text_offset, ONE_LEN);
         ctlt_pkg::CH_RBRACKET: add_token(ctlt_pkg::KIND_RBRACKET, text_offset, ONE_LEN);
         ctlt_pkg::CH_SQUOTE: begin
            lx_mode = LX_CHAR;
            open_start = bump(text_offset);
            open_len = '0;
         end
         ctlt_pkg::CH_DQUOTE: begin
            lx_mode = LX_STRING;
            open_start = bump(text_offset);
            open_len = '0;
         end
         default: begin
            if (is_letter(b) || b == ctlt_pkg::CH_UNDERSCORE) begin
               lx_mode = LX_IDENT;
               open_start = text_offset;
               open_len = ONE_LEN;
            end else if (is_numeral(b)) begin
               add_token(ctlt_pkg::KIND_IDENT, text_offset, ONE_LEN);
            end else begin
               add_token(ctlt_pkg::KIND_UNKNOWN, text_offset, ONE_LEN);
            end
         end
      endcase
      return ended;
   endfunction

   function automatic bit scan_literal(input logic [ctlt_pkg::BYTE_BITS-1:0] b,
                                       input logic [ctlt_pkg::BYTE_BITS-1:0] quote,
                                       input lex_mode_type body_mode,
                                       input lex_mode_type esc_mode,
                                       input logic [ctlt_pkg::KIND_BITS-1:0] kind);
      bit ended = 1'b0;
      if (b == ctlt_pkg::CH_NUL) begin
         ended = scan_fresh(b);
      end else if (lx_mode == esc_mode) begin
         open_len = bump(open_len);
         lx_mode = body_mode;
      end else if (b == quote) begin
         add_token(kind, open_start, open_len);
         lx_mode = LX_IDLE;
      end else begin
         open_len = bump(open_len);
         if (b == ctlt_pkg::CH_BACKSLASH) lx_mode = esc_mode;
      end
      return ended;
   endfunction

   // Appends the tokens that one accepted text byte should produce.
   function automatic void lex_byte(input logic [ctlt_pkg::BYTE_BITS-1:0] b);
      bit ended = 1'b0;
      ctlt_pkg::token_type tok;
      run_tokens.delete();
      case (lx_mode)
         LX_SLASH: begin
            if (b == ctlt_pkg::CH_SLASH) begin
               lx_mode = LX_LINE;
            end else if (b == ctlt_pkg::CH_STAR) begin
               lx_mode = LX_BLOCK;
            end else begin
               add_token(ctlt_pkg::KIND_UNKNOWN, open_start, ONE_LEN);
               ended = scan_fresh(b);
            end
         end
         LX_LINE: begin
            if (b == ctlt_pkg::CH_NUL) ended = scan_fresh(b);
            else if (b == ctlt_pkg::CH_LF || b == ctlt_pkg::CH_CR || b == ctlt_pkg::CH_VT)
               lx_mode = LX_IDLE;
         end
         LX_BLOCK: begin
            if (b == ctlt_pkg::CH_NUL) ended = scan_fresh(b);
            else if (b == ctlt_pkg::CH_STAR) lx_mode = LX_BLOCK_STAR;
         end
         LX_BLOCK_STAR: begin
            if (b == ctlt_pkg::CH_NUL) ended = scan_fresh(b);
            else if (b == ctlt_pkg::CH_SLASH) lx_mode = LX_IDLE;
            else if (b != ctlt_pkg::CH_STAR) lx_mode = LX_BLOCK;
         end
         LX_IDENT: begin
            if (is_letter(b) || is_numeral(b) || b == ctlt_pkg::CH_UNDERSCORE) begin
               open_len = bump(open_len);
            end else begin
               add_token(ctlt_pkg::KIND_IDENT, open_start, open_len);
               ended = scan_fresh(b);
            end
         end
         LX_STRING, LX_STRING_ESC: begin
            ended = scan_literal(b, ctlt_pkg::CH_DQUOTE, LX_STRING, LX_STRING_ESC,
                                 ctlt_pkg::KIND_STRING);
         end
         LX_CHAR, LX_CHAR_ESC: begin
            ended = scan_literal(b, ctlt_pkg::CH_SQUOTE, LX_CHAR, LX_CHAR_ESC,
                                 ctlt_pkg::KIND_CHAR);
         end
         default: ended = scan_fresh(b);
      endcase
      if (ended) begin
         lx_mode = LX_IDLE;
         text_offset = '0;
         open_start = '0;
         open_len = '0;
      end else begin
         text_offset = bump(text_offset);
      end
      for (int i = 0; i < run_tokens.size(); i++) begin
         tok = run_tokens[i];
         tok.last_of_run = (i == run_tokens.size() - 1);
         expected_tokens.push_back(tok);
      end
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (mismatches < MAX_PRINTS)
         $display("%0t: token %0d %s: got %0d, expected %0d",
                  $realtime, tokens_seen, what, got, want);
      mismatches++;
   endtask

   function automatic logic [ctlt_pkg::BYTE_BITS-1:0] punct_byte();
      case ($urandom_range(11))
         0: return ctlt_pkg::CH_COLON;
         1: return ctlt_pkg::CH_SEMICOLON;
         2: return ctlt_pkg::CH_COMMA;
         3: return ctlt_pkg::CH_STAR;
         4: return ctlt_pkg::CH_HASH;
         5: return ctlt_pkg::CH_PERIOD;
         6: return ctlt_pkg::CH_LPAREN;
         7: return ctlt_pkg::CH_RPAREN;
         8: return ctlt_pkg::CH_LBRACE;
         9: return ctlt_pkg::CH_RBRACE;
         10: return ctlt_pkg::CH_LBRACKET;
         default: return ctlt_pkg::CH_RBRACKET;
      endcase
   endfunction

   function automatic logic [ctlt_pkg::BYTE_BITS-1:0] blank_byte();
      case ($urandom_range(4))
         0: return ctlt_pkg::CH_SPACE;
         1: return ctlt_pkg::CH_TAB;
         2: return ctlt_pkg::CH_LF;
         3: return ctlt_pkg::CH_CR;
         default: return ctlt_pkg::CH_VT;
      endcase
   endfunction

   function automatic logic [ctlt_pkg::BYTE_BITS-1:0] name_byte(input bit first);
      case ($urandom_range(first ? 2 : 3))
         0: return 8'(CH_LOWER_A + $urandom_range(25));
         1: return 8'(CH_UPPER_A + $urandom_range(25));
         2: return ctlt_pkg::CH_UNDERSCORE;
         default: return 8'(CH_DIGIT_0 + $urandom_range(9));
      endcase
   endfunction

   // Any nonzero byte other than the two given ones.
   function automatic logic [ctlt_pkg::BYTE_BITS-1:0] body_byte(
      input logic [ctlt_pkg::BYTE_BITS-1:0] no_a,
      input logic [ctlt_pkg::BYTE_BITS-1:0] no_b);
      logic [ctlt_pkg::BYTE_BITS-1:0] b;
      do b = 8'($urandom_range(255, 1)); while (b == no_a || b == no_b);
      return b;
   endfunction

   // Queues one random lexeme; most are well formed, some are cut short.
   task automatic add_lexeme();
      int unsigned n;
      logic [ctlt_pkg::BYTE_BITS-1:0] quote;
      n = $urandom_range(8);
      case ($urandom_range(12))
         0, 1: text_bytes.push_back(punct_byte());
         2: text_bytes.push_back(blank_byte());
         3, 4: begin
            text_bytes.push_back(name_byte(1'b1));
            repeat (n) text_bytes.push_back(name_byte(1'b0));
         end
         5: text_bytes.push_back(8'(CH_DIGIT_0 + $urandom_range(9)));
         6, 7: begin
            quote = $urandom_range(1) ? ctlt_pkg::CH_DQUOTE : ctlt_pkg::CH_SQUOTE;
            text_bytes.push_back(quote);
            repeat (n) begin
               if ($urandom_range(4) == 0) begin
                  text_bytes.push_back(ctlt_pkg::CH_BACKSLASH);
                  text_bytes.push_back($urandom_range(1) ? quote :
                                       body_byte(ctlt_pkg::CH_NUL, ctlt_pkg::CH_NUL));
               end else begin
                  text_bytes.push_back(body_byte(quote, ctlt_pkg::CH_BACKSLASH));
               end
            end
            case ($urandom_range(9))
               0: text_bytes.push_back(ctlt_pkg::CH_NUL);
               1: begin
                  text_bytes.push_back(ctlt_pkg::CH_BACKSLASH);
                  text_bytes.push_back(ctlt_pkg::CH_NUL);
               end
               default: text_bytes.push_back(quote);
            endcase
         end
         8: begin
            text_bytes.push_back(ctlt_pkg::CH_SLASH);
            text_bytes.push_back(ctlt_pkg::CH_SLASH);
            repeat (n) text_bytes.push_back(body_byte(ctlt_pkg::CH_LF, ctlt_pkg::CH_CR));
            text_bytes.push_back($urandom_range(5) == 0 ? ctlt_pkg::CH_NUL : blank_byte());
         end
         9: begin
            text_bytes.push_back(ctlt_pkg::CH_SLASH);
            text_bytes.push_back(ctlt_pkg::CH_STAR);
            repeat (n) begin
               case ($urandom_range(3))
                  0: text_bytes.push_back(ctlt_pkg::CH_STAR);
                  1: text_bytes.push_back(ctlt_pkg::CH_SLASH);
                  default: text_bytes.push_back(body_byte(ctlt_pkg::CH_STAR,
                                                          ctlt_pkg::CH_SLASH));
               endcase
            end
            if ($urandom_range(5) == 0) begin
               text_bytes.push_back(ctlt_pkg::CH_NUL);
            end else begin
               text_bytes.push_back(ctlt_pkg::CH_STAR);
               text_bytes.push_back(ctlt_pkg::CH_SLASH);
            end
         end
         10: text_bytes.push_back(ctlt_pkg::CH_SLASH);
         11: text_bytes.push_back(8'($urandom_range(255)));
         default: text_bytes.push_back(ctlt_pkg::CH_NUL);
      endcase
   endtask

   // Sender: offers queued text bytes and predicts tokens on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready) lex_byte(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (text_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tdata <= text_bytes.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each accepted token against the oldest prediction.
   always @(posedge clock) begin
      ctlt_pkg::token_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               report_mismatch("unexpected, kind", rsp_tuser, 0);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_tuser != want.token_kind)
                  report_mismatch("kind", rsp_tuser, want.token_kind);
               if (rsp_tdata[15:0] != want.token_start)
                  report_mismatch("start", rsp_tdata[15:0], want.token_start);
               if (rsp_tdata[31:16] != want.token_length)
                  report_mismatch("length", rsp_tdata[31:16], want.token_length);
               if (rsp_tlast != want.last_of_run)
                  report_mismatch("last", rsp_tlast, want.last_of_run);
            end
            tokens_seen++;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         @(negedge clock);
         send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 83 : 0;
         recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 21 : 0;
         if (phase == 0) begin
            // Every punctuation, an escaped quote in a char literal, an identifier
            // closed by a slash, a slash closed by a semicolon, a star-slash overlap
            // in a block comment and end of text right after a string escape.
            text_bytes = '{ctlt_pkg::CH_COLON, ctlt_pkg::CH_SEMICOLON, ctlt_pkg::CH_COMMA,
                           ctlt_pkg::CH_STAR, ctlt_pkg::CH_HASH, ctlt_pkg::CH_PERIOD,
                           ctlt_pkg::CH_LPAREN, ctlt_pkg::CH_RPAREN, ctlt_pkg::CH_LBRACE,
                           ctlt_pkg::CH_RBRACE, ctlt_pkg::CH_LBRACKET,
                           ctlt_pkg::CH_RBRACKET, ctlt_pkg::CH_SQUOTE,
                           ctlt_pkg::CH_BACKSLASH, ctlt_pkg::CH_SQUOTE,
                           ctlt_pkg::CH_SQUOTE, CH_LOWER_A, ctlt_pkg::CH_UNDERSCORE,
                           CH_DIGIT_0 + 8'd9, ctlt_pkg::CH_SLASH, ctlt_pkg::CH_SEMICOLON,
                           ctlt_pkg::CH_SLASH, ctlt_pkg::CH_STAR, ctlt_pkg::CH_SLASH,
                           ctlt_pkg::CH_STAR, ctlt_pkg::CH_SLASH, 8'hFF,
                           ctlt_pkg::CH_DQUOTE, ctlt_pkg::CH_BACKSLASH, ctlt_pkg::CH_NUL};
         end
         while (text_bytes.size() < PHASE_BYTES)
            add_lexeme();
         while (text_bytes.size() != 0 || req_tvalid) @(posedge clock);
         while (expected_tokens.size() != 0) @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_tokens.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
